// File: rtl/core/ucb_pkg.sv
`timescale 1ns / 1ps

package ucb_pkg;

  localparam int ModeW     = 3;
  localparam int IdxW      = 8;
  localparam int CodeW     = 8;
  localparam int ViolW     = 3;
  localparam int CountOutW = 9;
  localparam int QDepth    = 2;

  localparam logic [ModeW-1:0] MODE_TRACK  = 3'd0;
  localparam logic [ModeW-1:0] MODE_ADD    = 3'd1;
  localparam logic [ModeW-1:0] MODE_CLOSE  = 3'd2;
  localparam logic [ModeW-1:0] MODE_FINISH = 3'd3;
  localparam logic [ModeW-1:0] MODE_ABORT  = 3'd4;

  localparam logic [ViolW-1:0] VIOL_NONE    = 3'd0;
  localparam logic [ViolW-1:0] VIOL_PHASE   = 3'd1;
  localparam logic [ViolW-1:0] VIOL_DUP     = 3'd2;
  localparam logic [ViolW-1:0] VIOL_MISSING = 3'd3;
  localparam logic [ViolW-1:0] VIOL_TWICE   = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_CLOSE,
    OP_FINISH,
    OP_ABORT
  } op_e;

  typedef enum logic [2:0] {
    PH_ACCEPT     = 3'b001,
    PH_REGISTERED = 3'b010,
    PH_DELIVERED  = 3'b100
  } phase_e;

  typedef struct packed {
    op_e              op;
    logic             idx_ok;
    logic [IdxW-1:0]  idx;
    logic [CodeW-1:0] code;
  } item_t;

  // declared high to low so completion_valid lands in bit 0
  typedef struct packed {
    logic [CodeW-1:0]     first_error;
    logic [CountOutW-1:0] inflight_count;
    logic [ViolW-1:0]     violation;
    logic                 submit_pending;
    logic [CodeW-1:0]     completion_status;
    logic                 completion_valid;
  } result_t;

endpackage

// File: rtl/core/ucb_front.sv
`timescale 1ns / 1ps

module ucb_front #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic [ucb_pkg::ModeW-1:0] mode_i,
  input  logic [ucb_pkg::IdxW-1:0]  block_index_i,
  input  logic [ucb_pkg::CodeW-1:0] error_code_i,
  output ucb_pkg::item_t            item_o
);

  always_comb begin
    item_o.idx    = block_index_i;
    item_o.code   = error_code_i;
    item_o.idx_ok = (32'(block_index_i) < MAX_BLOCKS);
    case (mode_i)
      ucb_pkg::MODE_TRACK, ucb_pkg::MODE_ADD: item_o.op = ucb_pkg::OP_INSERT;
      ucb_pkg::MODE_CLOSE:                    item_o.op = ucb_pkg::OP_CLOSE;
      ucb_pkg::MODE_FINISH:                   item_o.op = ucb_pkg::OP_FINISH;
      ucb_pkg::MODE_ABORT:                    item_o.op = ucb_pkg::OP_ABORT;
      default:                                item_o.op = ucb_pkg::OP_NOP;
    endcase
  end

endmodule

// File: rtl/core/ucb_queue.sv
`timescale 1ns / 1ps

module ucb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ucb_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ucb_pkg::item_t item_o
);

  localparam int PtrW = $clog2(ucb_pkg::QDepth);
  localparam int CntW = $clog2(ucb_pkg::QDepth + 1);

  ucb_pkg::item_t        entries_q [ucb_pkg::QDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CntW'(ucb_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(ucb_pkg::QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(ucb_pkg::QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/core/ucb_back.sv
`timescale 1ns / 1ps

module ucb_back #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ucb_pkg::item_t   item_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ucb_pkg::result_t res_o
);

  // indices past 255 can never arrive, so the map stops there
  localparam int MapDepth = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int MapIdxW  = $clog2(MapDepth);
  localparam int CntW     = $clog2(MapDepth + 1);

  logic [MapDepth-1:0]          map_q, map_d;
  ucb_pkg::phase_e              phase_q, phase_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [ucb_pkg::CodeW-1:0]    err_q, err_d;
  logic                         res_valid_q;
  ucb_pkg::result_t             res_q, res_d;

  logic [MapIdxW-1:0]           ix;
  logic                         hit;
  logic                         cv, sub;
  logic [ucb_pkg::CodeW-1:0]    cs;
  logic [ucb_pkg::ViolW-1:0]    viol;

  assign pop_o       = valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign ix          = item_i.idx[MapIdxW-1:0];
  assign hit         = map_q[ix];

  always_comb begin
    map_d   = map_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    cv      = 1'b0;
    cs      = '0;
    sub     = 1'b0;
    viol    = ucb_pkg::VIOL_NONE;
    case (item_i.op)
      ucb_pkg::OP_INSERT: begin
        if (phase_q != ucb_pkg::PH_ACCEPT) begin
          viol = ucb_pkg::VIOL_PHASE;
        end else if (!item_i.idx_ok) begin
          viol = ucb_pkg::VIOL_MISSING;
        end else if (hit) begin
          viol = ucb_pkg::VIOL_DUP;
        end else begin
          map_d[ix] = 1'b1;
          cnt_d     = cnt_q + CntW'(1);
        end
      end
      ucb_pkg::OP_CLOSE: begin
        if (phase_q != ucb_pkg::PH_ACCEPT) begin
          viol = ucb_pkg::VIOL_TWICE;
        end else if (err_q != '0 || cnt_q == '0) begin
          // sticky error is zero when nothing is outstanding and clean
          phase_d = ucb_pkg::PH_DELIVERED;
          cv      = 1'b1;
          cs      = err_q;
        end else begin
          phase_d = ucb_pkg::PH_REGISTERED;
          sub     = 1'b1;
        end
      end
      ucb_pkg::OP_FINISH: begin
        if (!item_i.idx_ok || !hit) begin
          viol = ucb_pkg::VIOL_MISSING;
        end else begin
          map_d[ix] = 1'b0;
          cnt_d     = cnt_q - CntW'(1);
          if (item_i.code != '0 && err_q == '0) begin
            err_d = item_i.code;
          end
          if (phase_q == ucb_pkg::PH_REGISTERED && cnt_q == CntW'(1)) begin
            phase_d = ucb_pkg::PH_DELIVERED;
            cv      = 1'b1;
            cs      = err_d;
          end
        end
      end
      ucb_pkg::OP_ABORT: begin
        if (phase_q != ucb_pkg::PH_ACCEPT) begin
          viol = ucb_pkg::VIOL_PHASE;
        end else begin
          phase_d = ucb_pkg::PH_DELIVERED;
          if (err_q == '0) begin
            err_d = item_i.code;
          end
          cv = 1'b1;
          cs = err_d;
        end
      end
      default: ;
    endcase

    res_d.completion_valid  = cv;
    res_d.completion_status = cs;
    res_d.submit_pending    = sub;
    res_d.violation         = viol;
    res_d.inflight_count    = ucb_pkg::CountOutW'(cnt_d);
    res_d.first_error       = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= '0;
      phase_q     <= ucb_pkg::PH_ACCEPT;
      cnt_q       <= '0;
      err_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        map_q   <= map_d;
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        err_q   <= err_d;
      end
      if (pop_o) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// File: rtl/core/upload_completion_barrier_core.sv
`timescale 1ns / 1ps
// Channel   Direction  tdata fields (low bit up)                 tuser
// s_axis    in         block_index[7:0] error_code[15:8]         mode[2:0]
// m_axis    out        completion_valid[0] completion_status[8:1] -
//                      submit_pending[9] violation[12:10]
//                      inflight_count[21:13] first_error[29:22]
//
// One item per cycle sustained while the output accepts results; a result is
// registered first in the classify queue and then in the scoreboard stage,
// whose single bitmap read-modify-write per cycle sets the rate.
// Reset clears the bitmap flops at once, so items are taken right after reset.
// A stalled result holds in the output register while the queue keeps filling.
module upload_completion_barrier_core #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // block_index, error_code
  input  logic [2:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // completion_valid, completion_status,
                                      // submit_pending, violation,
                                      // inflight_count, first_error
);

  ucb_pkg::item_t   front_item;
  ucb_pkg::item_t   queue_item;
  ucb_pkg::result_t result;
  logic             queue_full;
  logic             queue_valid;
  logic             back_pop;

  assign s_axis_tready = !queue_full;

  ucb_front #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_front (
    .mode_i        (s_axis_tuser),
    .block_index_i (s_axis_tdata[7:0]),
    .error_code_i  (s_axis_tdata[15:8]),
    .item_o        (front_item)
  );

  ucb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  ucb_back #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .item_i      (queue_item),
    .pop_o       (back_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (result)
  );

  assign m_axis_tdata = {2'b00, result};

endmodule

// File: rtl/core/ucb_checker.sv
`timescale 1ns / 1ps

module ucb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic       in_acc, out_acc;
  logic       cv;
  logic [8:0] cnt;
  logic [7:0] ferr;
  logic [2:0] pend_q;
  logic [8:0] last_cnt_q;
  logic [7:0] last_err_q;
  logic       done_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cv      = m_axis_tdata[0];
  assign cnt     = m_axis_tdata[21:13];
  assign ferr    = m_axis_tdata[29:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      last_cnt_q <= '0;
      last_err_q <= '0;
      done_q     <= 1'b0;
    end else begin
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc) begin
        last_cnt_q <= cnt;
        last_err_q <= ferr;
        if (cv) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("result without an accepted item");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> ({1'b0, cnt} == {1'b0, last_cnt_q}) ||
                ({1'b0, cnt} == {1'b0, last_cnt_q} + 10'd1) ||
                ({1'b0, cnt} + 10'd1 == {1'b0, last_cnt_q}))
    else $error("inflight count jumped");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_err_q != 8'd0 |-> ferr == last_err_q)
    else $error("first error changed");

  a_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && done_q |-> !cv)
    else $error("completion delivered twice");

endmodule

bind upload_completion_barrier_core ucb_checker u_ucb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/upload_completion_barrier_checker.sv
`timescale 1ns / 1ps

module upload_completion_barrier_checker
  import ucb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // block_index, error_code
  input  logic [2:0]  s_axis_tuser,   // mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // completion_valid, completion_status,
                                      // submit_pending, violation,
                                      // inflight_count, first_error
  output int          fail_count_o,
  output int          awaited_o
);

  // shadow of the barrier
  phase_e               barrier_phase;
  logic [255:0]         inflight_bits;
  logic [CountOutW-1:0] open_count;
  logic [CodeW-1:0]     first_err;

  result_t completion_q[$];
  result_t want;
  result_t got;
  int      bad_fields;

  function automatic result_t step_barrier(logic [ModeW-1:0] mode, logic [IdxW-1:0] idx,
                                           logic [CodeW-1:0] code);
    result_t r;
    r = '0;
    case (mode)
      MODE_TRACK, MODE_ADD: begin
        if (barrier_phase != PH_ACCEPT) begin
          r.violation = VIOL_PHASE;
        end else if (inflight_bits[idx]) begin
          r.violation = VIOL_DUP;
        end else begin
          inflight_bits[idx] = 1'b1;
          open_count = open_count + CountOutW'(1);
        end
      end
      MODE_CLOSE: begin
        if (barrier_phase != PH_ACCEPT) begin
          r.violation = VIOL_TWICE;
        end else if (first_err != '0) begin
          barrier_phase = PH_DELIVERED;
          r.completion_valid  = 1'b1;
          r.completion_status = first_err;
        end else if (open_count == '0) begin
          barrier_phase = PH_DELIVERED;
          r.completion_valid = 1'b1;
        end else begin
          barrier_phase = PH_REGISTERED;
          r.submit_pending = 1'b1;
        end
      end
      MODE_FINISH: begin
        if (!inflight_bits[idx]) begin
          r.violation = VIOL_MISSING;
        end else begin
          inflight_bits[idx] = 1'b0;
          open_count = open_count - CountOutW'(1);
          if (code != '0 && first_err == '0) first_err = code;
          if (barrier_phase == PH_REGISTERED && open_count == '0) begin
            barrier_phase = PH_DELIVERED;
            r.completion_valid  = 1'b1;
            r.completion_status = first_err;
          end
        end
      end
      MODE_ABORT: begin
        if (barrier_phase != PH_ACCEPT) begin
          r.violation = VIOL_PHASE;
        end else begin
          barrier_phase = PH_DELIVERED;
          // a zero code still latches here
          if (first_err == '0) first_err = code;
          r.completion_valid  = 1'b1;
          r.completion_status = first_err;
        end
      end
      default: ;
    endcase
    r.inflight_count = open_count;
    r.first_error    = first_err;
    return r;
  endfunction

  function automatic int field_bad(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      barrier_phase = PH_ACCEPT;
      inflight_bits = '0;
      open_count    = '0;
      first_err     = '0;
      completion_q.delete();
      bad_fields    = 0;
      fail_count_o <= 0;
      awaited_o    <= 0;
    end else begin
      // results leave only after their transaction has passed the queue and output register, so check before pushing
      if (m_axis_tvalid && m_axis_tready) begin
        if (completion_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          bad_fields++;
        end else begin
          want = completion_q.pop_front();
          got  = m_axis_tdata[$bits(result_t)-1:0];
          bad_fields += field_bad("completion_valid", want.completion_valid,
                                  got.completion_valid);
          bad_fields += field_bad("completion_status", want.completion_status,
                                  got.completion_status);
          bad_fields += field_bad("submit_pending", want.submit_pending, got.submit_pending);
          bad_fields += field_bad("violation", want.violation, got.violation);
          bad_fields += field_bad("inflight_count", want.inflight_count, got.inflight_count);
          bad_fields += field_bad("first_error", want.first_error, got.first_error);
          bad_fields += field_bad("tdata padding", 0, m_axis_tdata[31:$bits(result_t)]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        completion_q.push_back(step_barrier(s_axis_tuser, s_axis_tdata[7:0],
                                            s_axis_tdata[15:8]));
      end
      fail_count_o <= bad_fields;
      awaited_o    <= completion_q.size();
    end
  end

endmodule

// File: tb/upload_completion_barrier_core_tb.sv
`timescale 1ns / 1ps

module upload_completion_barrier_core_tb;
  import ucb_pkg::*;

  // modes the block ignores
  localparam logic [ModeW-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_RSVD7 = 3'd7;

  typedef enum int {
    END_REGISTERED,
    END_STICKY,
    END_EMPTY,
    END_ABORT
  } finale_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  int          mismatches;
  int          awaited;

  bit           tail_phase;
  bit           open_phase;
  bit           errors_allowed;
  int unsigned  gap_pct;
  bit [255:0]   live_map;
  int           live_count;

  upload_completion_barrier_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  upload_completion_barrier_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (mismatches),
    .awaited_o     (awaited)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic offer(logic [ModeW-1:0] mode, logic [IdxW-1:0] idx, logic [CodeW-1:0] code);
    if (!tail_phase && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {code, idx};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic track_block(logic [ModeW-1:0] mode, logic [IdxW-1:0] idx,
                             logic [CodeW-1:0] code);
    offer(mode, idx, code);
    if (open_phase && !live_map[idx]) begin
      live_map[idx] = 1'b1;
      live_count++;
    end
  endtask

  task automatic finish_block(logic [IdxW-1:0] idx, logic [CodeW-1:0] code);
    offer(MODE_FINISH, idx, code);
    if (live_map[idx]) begin
      live_map[idx] = 1'b0;
      live_count--;
    end
  endtask

  function automatic logic [ModeW-1:0] insert_mode();
    return $urandom_range(0, 1) ? MODE_ADD : MODE_TRACK;
  endfunction

  // callers make sure at least one block is outstanding
  function automatic logic [IdxW-1:0] pick_live();
    logic [IdxW-1:0] k;
    k = IdxW'($urandom_range(0, 255));
    while (!live_map[k]) k++;
    return k;
  endfunction

  function automatic logic [CodeW-1:0] status_code(int unsigned err_pct);
    return ($urandom_range(1, 100) <= err_pct) ? CodeW'($urandom_range(1, 255)) : '0;
  endfunction

  task automatic random_open_step(int unsigned insert_pct);
    int unsigned     r;
    logic [IdxW-1:0] idx;
    r   = $urandom_range(1, 100);
    idx = IdxW'($urandom);
    if (r <= insert_pct) begin
      track_block(insert_mode(), idx, CodeW'($urandom));
    end else if (r <= insert_pct + 35 && live_count > 0) begin
      finish_block(pick_live(), status_code(errors_allowed ? 15 : 0));
    end else if (r <= 93) begin
      finish_block(idx, live_map[idx] ? status_code(errors_allowed ? 15 : 0)
                                      : CodeW'($urandom));
    end else begin
      offer(ModeW'($urandom_range(MODE_RSVD5, MODE_RSVD7)), idx, CodeW'($urandom));
    end
  endtask

  task automatic noise_after_close();
    logic [IdxW-1:0] idx;
    idx = IdxW'($urandom);
    case ($urandom_range(0, 4))
      0: track_block(insert_mode(), idx, CodeW'($urandom));
      1: offer(MODE_CLOSE, idx, CodeW'($urandom));
      2: offer(MODE_ABORT, idx, CodeW'($urandom));
      3: finish_block(idx, status_code(30));
      default: offer(ModeW'($urandom_range(MODE_RSVD5, MODE_RSVD7)), idx, CodeW'($urandom));
    endcase
  endtask

  initial begin : sink_proc
    int unsigned rx_cycles;
    int unsigned next_window;
    int unsigned stall_pct;
    int unsigned hold;
    bit          squeezed;
    m_axis_tready = 1'b0;
    rx_cycles   = 0;
    next_window = 0;
    stall_pct   = 0;
    squeezed    = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_cycles >= next_window) begin
        next_window += 64;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (!squeezed && rx_cycles >= 300) begin
        // long hold-off so the block fills and backs up its input
        squeezed = 1'b1;
        hold = 120;
      end else if (!tail_phase && $urandom_range(1, 100) <= stall_pct) begin
        hold = $urandom_range(1, 8);
      end else begin
        hold = 0;
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        rx_cycles += hold;
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
        rx_cycles++;
      end
    end
  end

  initial begin : stimulus
    finale_e     finale;
    int unsigned post;
    logic [7:0]  base;
    logic [7:0]  stride;
    logic [7:0]  idx;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    tail_phase     = 1'b0;
    open_phase     = 1'b1;
    gap_pct        = 0;
    live_map       = '0;
    live_count     = 0;
    finale         = finale_e'($urandom_range(0, 3));
    errors_allowed = (finale == END_STICKY) || (finale == END_ABORT && $urandom_range(0, 1));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: index and code extremes, duplicates, missing finishes, ignored modes.
    // Close and abort end the session for good, so they come at the end only.
    finish_block(8'h00, 8'hff);
    track_block(MODE_TRACK, 8'h00, 8'h00);
    track_block(MODE_TRACK, 8'h00, 8'hff);
    track_block(MODE_ADD, 8'hff, 8'h00);
    track_block(MODE_ADD, 8'hff, 8'h5a);
    track_block(MODE_ADD, 8'h00, 8'ha5);
    finish_block(8'hff, 8'h00);
    finish_block(8'hff, 8'ha5);
    offer(MODE_RSVD5, 8'haa, 8'h55);
    offer(MODE_RSVD5 + 3'd1, 8'h55, 8'haa);
    offer(MODE_RSVD7, 8'hff, 8'hff);
    track_block(MODE_ADD, 8'h80, 8'h00);
    track_block(MODE_TRACK, 8'h01, 8'h00);
    finish_block(8'h01, 8'h00);
    track_block(MODE_TRACK, 8'h7f, 8'h00);
    if (errors_allowed) finish_block(8'h80, 8'h80);

    gap_pct = 20;
    repeat (300) random_open_step(45);

    // fill every index so the count reaches its top
    gap_pct = 0;
    base    = 8'($urandom);
    stride  = 8'($urandom) | 8'h01;
    for (int i = 0; i < 256; i++) begin
      idx = base + 8'(i) * stride;
      if (!live_map[idx]) track_block(insert_mode(), idx, 8'($urandom));
    end
    repeat (3) track_block(insert_mode(), pick_live(), 8'($urandom));

    gap_pct = 50;
    repeat (200) random_open_step(30);

    gap_pct = 10;
    case (finale)
      END_REGISTERED: begin
        if (live_count == 0) track_block(insert_mode(), 8'($urandom), 8'($urandom));
        offer(MODE_CLOSE, 8'($urandom), 8'($urandom));
      end
      END_STICKY: begin
        if (live_count == 0) track_block(insert_mode(), 8'($urandom), 8'($urandom));
        finish_block(pick_live(), 8'($urandom_range(1, 255)));
        offer(MODE_CLOSE, 8'($urandom), 8'($urandom));
      end
      END_EMPTY: begin
        while (live_count > 0) finish_block(pick_live(), 8'h00);
        offer(MODE_CLOSE, 8'($urandom), 8'($urandom));
      end
      default: offer(MODE_ABORT, 8'($urandom), status_code(50));
    endcase
    open_phase = 1'b0;

    gap_pct = 15;
    post = 0;
    while (live_count > 0 || post < 30) begin
      if (live_count > 0 && $urandom_range(0, 9) < 7) finish_block(pick_live(), status_code(30));
      else noise_after_close();
      post++;
    end
    tail_phase = 1'b1;
    repeat (40) noise_after_close();
    s_axis_tvalid <= 1'b0;

    while (awaited != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
